[rtl/md5_digest_defines.svh]
// Assertion macros shared by the MD5 digest checker.
`ifndef MD5_DIGEST_DEFINES_SVH
`define MD5_DIGEST_DEFINES_SVH

// Property that is checked on every clock edge, reset included
`define MD5_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// Property that is masked while reset is asserted
`define MD5_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

[rtl/md5_pkg.sv]
// Types, constants and helper functions of the MD5 digest block.
`timescale 1ns / 1ps

package md5_pkg;

    // Block buffer geometry and queue depth
    localparam int BUF_DEPTH   = 16;
    localparam int BUF_AW      = $clog2(BUF_DEPTH);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0]  FULL_BYTES = 3'd4;
    localparam logic [31:0] PAD_WORD   = 32'h0000_0080;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [1:0]  LAST_INDEX = 2'd3;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [3:0]  POS_LEN_LO = 4'd14;
    localparam logic [3:0]  POS_LEN_HI = 4'd15;

    // Round groups (top two bits of the round number)
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    // Initial chaining words, index 0 = a
    localparam logic [3:0][31:0] CHAIN_IV = {
        32'h1032_5476, 32'h98ba_dcfe, 32'hefcd_ab89, 32'h6745_2301
    };

    // Additive round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {group, round[1:0]}
    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Input item
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } md5_in_t;

    // Result item
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_result;
    } md5_out_t;

    // Queue entry from front to back
    typedef struct packed {
        logic [31:0] word;      // buffer word, pad byte already merged on a short last word
        logic        last;      // final word of the message
        logic        extra_pad; // last word was full, 0x80 goes in a word of its own
        logic [63:0] bit_len;   // message length in bits, valid with last
    } md5_entry_t;

    // Back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PAD,
        BK_LOAD,
        BK_ROUND,
        BK_ADD,
        BK_OUT
    } bk_state_t;

    // Buffer word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [7:0] t;
        t = 8'd0;
        unique case (rnd[5:4])
            GRP_F: t = {2'b00, rnd};
            GRP_G: t = {2'b00, rnd} * 8'd5 + 8'd1;
            GRP_H: t = {2'b00, rnd} * 8'd3 + 8'd5;
            GRP_I: t = {2'b00, rnd} * 8'd7;
            default: t = 8'd0;
        endcase
        return t[3:0];
    endfunction

    // Left rotate of a 32-bit word
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

[rtl/md5_digest.sv]
// Top level of the MD5 digest block: front end, entry queue and round engine.
`timescale 1ns / 1ps

// MD5 over a byte message fed as little-endian 32-bit words on the s_ channel;
// after the flagged last word the four digest words a, b, c, d leave on the
// m_ channel with last_result on d. The front end takes one word per cycle,
// while the queue has room, into a short queue; the back end writes one word
// per cycle, while idle, into a 16-entry block buffer with one write port,
// and each full block then passes through the single round unit (one load
// step, 64 rounds, one add) before the next words are taken. The last word
// adds one padding write per free buffer slot, a second block when the
// length does not fit, and four output transfers, after which the block is
// back at its initial state for the next message.
module md5_digest #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  md5_pkg::md5_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output md5_pkg::md5_out_t m_data
);

    md5_pkg::md5_entry_t push_entry;
    md5_pkg::md5_entry_t head_entry;
    logic                q_push, q_full, q_pop, q_valid;

    md5_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    md5_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head_entry),
        .not_empty  (q_valid)
    );

    md5_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (head_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/md5_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = md5_pkg::BUF_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/md5_front.sv]
// Front end: accepts message words, counts bytes and builds queue entries.
`timescale 1ns / 1ps

module md5_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  md5_pkg::md5_in_t   s_data,
    input  logic               q_full,
    output logic               q_push,
    output md5_pkg::md5_entry_t q_entry
);

    logic [63:0] bytes_reg;
    logic [63:0] bytes_next;
    logic [63:0] total;
    logic [2:0]  cnt;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Valid byte count of this word, saturated to four on the last word
    always_comb begin
        if (!s_data.last_word) begin
            cnt = md5_pkg::FULL_BYTES;
        end else if (s_data.byte_count > md5_pkg::FULL_BYTES) begin
            cnt = md5_pkg::FULL_BYTES;
        end else begin
            cnt = s_data.byte_count;
        end
    end

    assign total = bytes_reg + {61'd0, cnt};

    // Mask invalid bytes and merge the pad byte into a short last word
    always_comb begin
        q_entry           = '0;
        q_entry.last      = s_data.last_word;
        q_entry.bit_len   = {total[60:0], 3'b000};
        q_entry.extra_pad = 1'b0;
        if (!s_data.last_word) begin
            q_entry.word = s_data.data_word;
        end else begin
            unique case (cnt)
                3'd0: q_entry.word = md5_pkg::PAD_WORD;
                3'd1: q_entry.word = {16'd0, md5_pkg::PAD_BYTE, s_data.data_word[7:0]};
                3'd2: q_entry.word = {8'd0, md5_pkg::PAD_BYTE, s_data.data_word[15:0]};
                3'd3: q_entry.word = {md5_pkg::PAD_BYTE, s_data.data_word[23:0]};
                default: begin
                    q_entry.word      = s_data.data_word;
                    q_entry.extra_pad = 1'b1;
                end
            endcase
        end
    end

    // Running byte count, restarted after the last word
    always_comb begin
        bytes_next = bytes_reg;
        if (q_push) begin
            bytes_next = s_data.last_word ? 64'd0 : total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= 64'd0;
        end else begin
            bytes_reg <= bytes_next;
        end
    end

endmodule

[rtl/md5_queue.sv]
// Short FIFO of entries between the front and back ends.
`timescale 1ns / 1ps

module md5_queue #(
    parameter int DEPTH = md5_pkg::QUEUE_DEPTH,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  md5_pkg::md5_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output md5_pkg::md5_entry_t head,
    output logic                not_empty
);

    md5_pkg::md5_entry_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/md5_back.sv]
// Back end: fills the block buffer, pads, runs the rounds and emits the digest.
`timescale 1ns / 1ps

module md5_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  md5_pkg::md5_entry_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output md5_pkg::md5_out_t   m_data
);

    md5_pkg::bk_state_t state_reg, state_next;
    logic [3:0]        wpos_reg, wpos_next;
    logic [5:0]        rnd_reg, rnd_next;
    logic [3:0][31:0]  chain_reg, chain_next;
    logic [3:0][31:0]  work_reg, work_next;
    logic              fin_reg, fin_next;
    logic              extra_reg, extra_next;
    logic              lo_done_reg, lo_done_next;
    logic              len_done_reg, len_done_next;
    logic [63:0]       bit_len_reg, bit_len_next;
    logic [1:0]        out_idx_reg, out_idx_next;
    logic              m_valid_reg, m_valid_next;
    md5_pkg::md5_out_t m_data_reg, m_data_next;

    // Buffer port signals
    logic        buf_we;
    logic [31:0] buf_wdata;
    logic [3:0]  buf_raddr;
    logic [31:0] buf_rdata;

    // Round datapath
    logic [31:0] f_val;
    logic [31:0] round_sum;
    logic [31:0] round_rot;
    logic [5:0]  rnd_inc;

    md5_ram #(
        .WIDTH (32),
        .DEPTH (md5_pkg::BUF_DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (wpos_reg),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign rnd_inc = rnd_reg + 6'd1;

    // One MD5 round on A..D held in work_reg, message word from the buffer
    always_comb begin
        unique case (rnd_reg[5:4])
            md5_pkg::GRP_F: f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            md5_pkg::GRP_G: f_val = (work_reg[3] & work_reg[1]) | (~work_reg[3] & work_reg[2]);
            md5_pkg::GRP_H: f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            md5_pkg::GRP_I: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
            default:        f_val = '0;
        endcase
        round_sum = f_val + work_reg[0] + md5_pkg::ROUND_K[rnd_reg] + buf_rdata;
        round_rot = md5_pkg::rotl32(round_sum,
                                    md5_pkg::ROT_AMT[{rnd_reg[5:4], rnd_reg[1:0]}]);
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        wpos_next     = wpos_reg;
        rnd_next      = rnd_reg;
        chain_next    = chain_reg;
        work_next     = work_reg;
        fin_next      = fin_reg;
        extra_next    = extra_reg;
        lo_done_next  = lo_done_reg;
        len_done_next = len_done_reg;
        bit_len_next  = bit_len_reg;
        out_idx_next  = out_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        q_pop         = 1'b0;
        buf_we        = 1'b0;
        buf_wdata     = '0;
        buf_raddr     = '0;

        unique case (state_reg)
            // Take one entry from the queue into the buffer
            md5_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    buf_we    = 1'b1;
                    buf_wdata = q_head.word;
                    wpos_next = wpos_reg + 4'd1;
                    if (q_head.last) begin
                        fin_next     = 1'b1;
                        extra_next   = q_head.extra_pad;
                        bit_len_next = q_head.bit_len;
                    end
                    if (wpos_reg == md5_pkg::POS_LEN_HI) begin
                        state_next = md5_pkg::BK_LOAD;
                    end else if (q_head.last) begin
                        state_next = md5_pkg::BK_PAD;
                    end
                end
            end
            // Padding: lone pad byte, zeros, then the bit length
            md5_pkg::BK_PAD: begin
                buf_we    = 1'b1;
                wpos_next = wpos_reg + 4'd1;
                priority if (extra_reg) begin
                    buf_wdata  = md5_pkg::PAD_WORD;
                    extra_next = 1'b0;
                end else if (wpos_reg == md5_pkg::POS_LEN_LO) begin
                    buf_wdata    = bit_len_reg[31:0];
                    lo_done_next = 1'b1;
                end else if (wpos_reg == md5_pkg::POS_LEN_HI && lo_done_reg) begin
                    buf_wdata     = bit_len_reg[63:32];
                    len_done_next = 1'b1;
                end else begin
                    buf_wdata = '0;
                end
                if (wpos_reg == md5_pkg::POS_LEN_HI) begin
                    state_next = md5_pkg::BK_LOAD;
                end
            end
            // Copy chaining words and fetch the first message word
            md5_pkg::BK_LOAD: begin
                work_next  = chain_reg;
                rnd_next   = '0;
                buf_raddr  = md5_pkg::msg_index('0);
                state_next = md5_pkg::BK_ROUND;
            end
            // One round per cycle, next word fetched alongside
            md5_pkg::BK_ROUND: begin
                work_next[0] = work_reg[3];
                work_next[1] = work_reg[1] + round_rot;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                buf_raddr    = md5_pkg::msg_index(rnd_inc);
                rnd_next     = rnd_inc;
                if (rnd_reg == md5_pkg::LAST_ROUND) begin
                    state_next = md5_pkg::BK_ADD;
                end
            end
            // Fold the block result into the chaining words
            md5_pkg::BK_ADD: begin
                for (int k = 0; k < 4; k++) begin
                    chain_next[k] = chain_reg[k] + work_reg[k];
                end
                priority if (len_done_reg) begin
                    state_next = md5_pkg::BK_OUT;
                end else if (fin_reg) begin
                    state_next = md5_pkg::BK_PAD;
                end else begin
                    state_next = md5_pkg::BK_IDLE;
                end
            end
            // Hand out the digest words a, b, c, d
            md5_pkg::BK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.digest_word  = chain_reg[out_idx_reg];
                    m_data_next.word_index   = out_idx_reg;
                    m_data_next.last_result  = (out_idx_reg == md5_pkg::LAST_INDEX);
                    out_idx_next             = out_idx_reg + 2'd1;
                    if (out_idx_reg == md5_pkg::LAST_INDEX) begin
                        chain_next    = md5_pkg::CHAIN_IV;
                        fin_next      = 1'b0;
                        extra_next    = 1'b0;
                        lo_done_next  = 1'b0;
                        len_done_next = 1'b0;
                        state_next    = md5_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = md5_pkg::BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= md5_pkg::BK_IDLE;
            wpos_reg     <= '0;
            rnd_reg      <= '0;
            chain_reg    <= md5_pkg::CHAIN_IV;
            fin_reg      <= 1'b0;
            extra_reg    <= 1'b0;
            lo_done_reg  <= 1'b0;
            len_done_reg <= 1'b0;
            out_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wpos_reg     <= wpos_next;
            rnd_reg      <= rnd_next;
            chain_reg    <= chain_next;
            fin_reg      <= fin_next;
            extra_reg    <= extra_next;
            lo_done_reg  <= lo_done_next;
            len_done_reg <= len_done_next;
            out_idx_reg  <= out_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        work_reg    <= work_next;
        bit_len_reg <= bit_len_next;
        m_data_reg  <= m_data_next;
    end

endmodule

[rtl/md5_checker.sv]
// Port-level checks on the MD5 digest block, bound to the top level.
`timescale 1ns / 1ps
`include "md5_digest_defines.svh"

module md5_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input md5_pkg::md5_out_t m_data
);

    logic       m_xfer;
    logic       mid_xfer;
    logic       is_d;
    logic [1:0] idx_succ;

    // Result transfer, word d and the index that should come next
    assign m_xfer   = m_valid && m_ready;
    assign mid_xfer = m_xfer && !m_data.last_result;
    assign is_d     = (m_data.word_index == md5_pkg::LAST_INDEX);
    assign idx_succ = m_data.word_index + 2'd1;

    // No result right after reset
    `MD5_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds
    `MD5_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result moved")

    // Last flag marks word d only
    `MD5_ASSERT(a_last_on_d, m_valid |-> m_data.last_result == is_d, "last flag not on word d")

    // Digest words follow each other without gaps, in order
    `MD5_ASSERT(a_word_order, mid_xfer |=> m_valid && m_data.word_index == $past(idx_succ), "digest word order broken")

    // Nothing follows word d straight away
    `MD5_ASSERT(a_gap_after_d, m_xfer && m_data.last_result |=> !m_valid, "result right after word d")

endmodule

bind md5_digest md5_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
